// ===== design/sqd_pkg.sv =====
// sqd_pkg: shared types and constants of the shortest-queue dispatcher
// used by every module of the block; depends on nothing
`default_nettype none

package sqd_pkg;

	// field widths and sizes
	localparam int NODE_W      = 6;
	localparam int NODES       = 64;
	localparam int LEN_W       = 8;
	localparam int DIST_W      = 9;
	localparam int CNT_W       = 3;
	localparam int CAND_SLOTS  = 5;
	localparam int SLOT_W      = 3;
	localparam int MODE_W      = 2;
	localparam int SIZE_W      = 7;
	localparam int WEIGHT_W    = 8;
	localparam int APB_AW      = 5;
	localparam int APB_DW      = 32;

	localparam logic [LEN_W-1:0] MAX_LENGTH = 8'd255;
	localparam logic [CNT_W-1:0] MAX_EXTRA  = 3'd4;

	// fault codes
	localparam logic [1:0] FAULT_OK    = 2'd0;
	localparam logic [1:0] FAULT_SAT   = 2'd1;
	localparam logic [1:0] FAULT_EMPTY = 2'd2;

	// distance rules
	localparam logic [MODE_W-1:0] MODE_CYCLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRID    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLUSTER = 2'd2;

	// register indexes (byte address bits [4:2])
	localparam logic [2:0] REG_NUM_NODES    = 3'd0;
	localparam logic [2:0] REG_TOPOLOGY     = 3'd1;
	localparam logic [2:0] REG_GRID_WIDTH   = 3'd2;
	localparam logic [2:0] REG_CLUSTER_SIZE = 3'd3;
	localparam logic [2:0] REG_HOP_WEIGHT   = 3'd4;

	typedef struct packed {
		logic              action;
		logic [NODE_W-1:0] source_node;
		logic [CNT_W-1:0]  extra_count;
		logic [NODE_W-1:0] cand_a;
		logic [NODE_W-1:0] cand_b;
		logic [NODE_W-1:0] cand_c;
		logic [NODE_W-1:0] cand_d;
		logic [NODE_W-1:0] completed_node;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] chosen_node;
		logic [LEN_W-1:0]  new_length;
		logic [DIST_W-1:0] route_distance;
		logic              start_service;
		logic              became_empty;
		logic [1:0]        fault;
	} out_item_t;

	// classified job between front and back; slot 0 is source or completed node
	typedef struct packed {
		logic                                is_completion;
		logic [CNT_W-1:0]                    count;
		logic [CAND_SLOTS-1:0][NODE_W-1:0]   nodes;
	} job_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   num_nodes;
		logic [MODE_W-1:0]   topology_mode;
		logic [SIZE_W-1:0]   grid_width;
		logic [SIZE_W-1:0]   cluster_size;
		logic [WEIGHT_W-1:0] hop_weight;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/sqd_front.sv =====
// sqd_front: accepts commands, classifies them into jobs, holds a two-entry queue
// depends on sqd_pkg
`default_nettype none

module sqd_front
	import sqd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire in_item_t cmd,
	output logic          busy,
	output logic          avail,
	input  wire logic     pop,
	output job_t          head
);

	job_t       job;
	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify: completion uses slot 0 only, arrival clamps its candidate count
	always_comb begin
		job.is_completion = cmd.action;
		job.nodes[0]      = cmd.action ? cmd.completed_node : cmd.source_node;
		job.nodes[1]      = cmd.cand_a;
		job.nodes[2]      = cmd.cand_b;
		job.nodes[3]      = cmd.cand_c;
		job.nodes[4]      = cmd.cand_d;
		if (cmd.action)
			job.count = '0;
		else if (cmd.extra_count > MAX_EXTRA)
			job.count = MAX_EXTRA;
		else
			job.count = cmd.extra_count;
	end

	assign busy  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign push  = start && !busy;
	assign head  = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= job;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && avail)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !(pop && avail))
				cnt_q <= cnt_q + 2'd1;
			else if (!push && pop && avail)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== design/sqd_dist.sv =====
// sqd_dist: routing distance unit, cycle rule directly, grid and cluster by a
// bit-serial divider over the node index; depends on sqd_pkg
`default_nettype none

module sqd_dist
	import sqd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [NODE_W-1:0] u,
	input  wire logic [NODE_W-1:0] v,
	input  wire cfg_t              cfg,
	output logic                   done,
	output logic [DIST_W-1:0]      route_dist
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] rem;
		logic [NODE_W-1:0] quo;
	} div_t;

	localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(NODE_W - 1);

	state_t            state_q;
	div_t              du_q;
	div_t              dv_q;
	logic [SIZE_W-1:0] divisor_q;
	logic [SLOT_W-1:0] step_q;
	logic              is_grid_q;
	logic              done_q;
	logic [DIST_W-1:0] dist_q;

	logic [NODE_W-1:0]   diff;
	logic [SIZE_W-1:0]   wrap;
	logic [DIST_W-1:0]   cyc_dist;
	logic [WEIGHT_W-1:0] weight;
	logic [SIZE_W-1:0]   sel_div;
	div_t                du_nx;
	div_t                dv_nx;
	logic [NODE_W-1:0]   qdiff;
	logic [NODE_W-1:0]   rdiff;

	// one restoring division step: shift in the next dividend bit
	function automatic div_t div_step(div_t d, logic [SIZE_W-1:0] divisor);
		logic [SIZE_W:0] trial;
		div_t            r;
		trial = {d.rem, d.quo[NODE_W-1]};
		if (trial >= {1'b0, divisor}) begin
			r.rem = SIZE_W'(trial - {1'b0, divisor});
			r.quo = {d.quo[NODE_W-2:0], 1'b1};
		end else begin
			r.rem = trial[SIZE_W-1:0];
			r.quo = {d.quo[NODE_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// cycle distance with wraparound
	always_comb begin
		diff = (u > v) ? (u - v) : (v - u);
		wrap = cfg.num_nodes - {1'b0, diff};
		if (cfg.num_nodes > {1'b0, diff} && wrap < {1'b0, diff})
			cyc_dist = DIST_W'(wrap);
		else
			cyc_dist = DIST_W'(diff);
	end

	assign weight  = (cfg.hop_weight == '0) ? WEIGHT_W'(1) : cfg.hop_weight;
	assign sel_div = (cfg.topology_mode == MODE_GRID) ? cfg.grid_width : cfg.cluster_size;
	assign du_nx   = div_step(du_q, divisor_q);
	assign dv_nx   = div_step(dv_q, divisor_q);

	// grid distance from quotient and remainder differences
	assign qdiff = (du_q.quo > dv_q.quo) ? (du_q.quo - dv_q.quo) : (dv_q.quo - du_q.quo);
	assign rdiff = (du_q.rem[NODE_W-1:0] > dv_q.rem[NODE_W-1:0])
		? (du_q.rem[NODE_W-1:0] - dv_q.rem[NODE_W-1:0])
		: (dv_q.rem[NODE_W-1:0] - du_q.rem[NODE_W-1:0]);

	assign done       = done_q;
	assign route_dist = dist_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			dist_q    <= '0;
			du_q      <= '0;
			dv_q      <= '0;
			divisor_q <= '0;
			step_q    <= '0;
			is_grid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						if (u == v) begin
							dist_q <= '0;
							done_q <= 1'b1;
						end else if (cfg.topology_mode == MODE_CYCLE) begin
							dist_q <= cyc_dist;
							done_q <= 1'b1;
						end else if (cfg.topology_mode == MODE_GRID && sel_div == '0) begin
							dist_q <= '0;
							done_q <= 1'b1;
						end else if (cfg.topology_mode == MODE_CLUSTER && sel_div == '0) begin
							dist_q <= DIST_W'(weight);
							done_q <= 1'b1;
						end else if (cfg.topology_mode == MODE_GRID ||
						             cfg.topology_mode == MODE_CLUSTER) begin
							du_q      <= '{rem: '0, quo: u};
							dv_q      <= '{rem: '0, quo: v};
							divisor_q <= sel_div;
							is_grid_q <= (cfg.topology_mode == MODE_GRID);
							step_q    <= '0;
							state_q   <= ST_DIV;
						end else begin
							dist_q <= '0;
							done_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					du_q   <= du_nx;
					dv_q   <= dv_nx;
					step_q <= step_q + SLOT_W'(1);
					if (step_q == LAST_STEP)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (is_grid_q)
						dist_q <= DIST_W'(qdiff) + DIST_W'(rdiff);
					else if (du_q.quo == dv_q.quo)
						dist_q <= DIST_W'(weight);
					else
						dist_q <= {weight, 1'b0};
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/sqd_back.sv =====
// sqd_back: scans candidate queue lengths, updates the length memory, reports results
// depends on sqd_pkg and sqd_dist
`default_nettype none

module sqd_back
	import sqd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  avail,
	output logic       pop,
	input  wire job_t  head,
	output logic       done,
	output out_item_t  result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPD,
		ST_DIST
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic [SLOT_W-1:0] cmp_idx_q;
	logic              cmp_vld_q;
	logic [NODE_W-1:0] best_node_q;
	logic [LEN_W-1:0]  best_len_q;
	logic              done_q;
	out_item_t         result_q;
	logic              dist_go_q;

	// length memory with per-entry valid bits
	logic [LEN_W-1:0]  len_mem [NODES];
	logic [NODES-1:0]  vld_q;
	logic [LEN_W-1:0]  rd_data_s1;
	logic              rd_vld_s1;
	logic [NODE_W-1:0] rd_addr;
	logic [LEN_W-1:0]  rd_len;
	logic              wr_en;
	logic [LEN_W-1:0]  wr_data;

	logic [LEN_W-1:0]  upd_len;
	logic              upd_start;
	logic              upd_empty;
	logic [1:0]        upd_fault;

	logic              dist_done;
	logic [DIST_W-1:0] dist_val;

	assign rd_addr = job_q.nodes[rd_idx_q];
	assign rd_len  = rd_vld_s1 ? rd_data_s1 : '0;
	assign pop     = (state_q == ST_IDLE) && avail;
	assign wr_en   = (state_q == ST_UPD);
	assign wr_data = upd_len;
	assign done    = done_q;
	assign result  = result_q;

	// memory read and write ports
	always_ff @(posedge clk) begin
		rd_data_s1 <= len_mem[rd_addr];
		if (wr_en)
			len_mem[best_node_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[rd_addr];
			if (wr_en)
				vld_q[best_node_q] <= 1'b1;
		end
	end

	// new length and flags for the chosen node
	always_comb begin
		upd_start = 1'b0;
		upd_empty = 1'b0;
		upd_fault = FAULT_OK;
		if (!job_q.is_completion) begin
			if (best_len_q >= MAX_LENGTH) begin
				upd_len   = MAX_LENGTH;
				upd_fault = FAULT_SAT;
			end else begin
				upd_len   = best_len_q + LEN_W'(1);
				upd_start = (best_len_q == '0);
			end
		end else begin
			if (best_len_q == '0) begin
				upd_len   = '0;
				upd_fault = FAULT_EMPTY;
			end else begin
				upd_len   = best_len_q - LEN_W'(1);
				upd_empty = (best_len_q == LEN_W'(1));
			end
		end
	end

	sqd_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (dist_go_q),
		.u          (job_q.nodes[0]),
		.v          (best_node_q),
		.cfg        (cfg),
		.done       (dist_done),
		.route_dist (dist_val)
	);

	// sequencer: scan candidates one read per cycle, compare each in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			cmp_vld_q   <= 1'b0;
			best_node_q <= '0;
			best_len_q  <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
			dist_go_q   <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			dist_go_q <= 1'b0;

			// compare stage: strict less keeps the earlier candidate on a tie
			if (cmp_vld_q) begin
				if (cmp_idx_q == '0 || rd_len < best_len_q) begin
					best_node_q <= job_q.nodes[cmp_idx_q];
					best_len_q  <= rd_len;
				end
			end

			case (state_q)
				ST_IDLE: begin
					cmp_vld_q <= 1'b0;
					if (avail) begin
						job_q    <= head;
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= 1'b1;
					cmp_idx_q <= rd_idx_q;
					if (rd_idx_q == job_q.count)
						state_q <= ST_LAST;
					else
						rd_idx_q <= rd_idx_q + SLOT_W'(1);
				end
				ST_LAST: begin
					cmp_vld_q <= 1'b0;
					state_q   <= ST_UPD;
				end
				ST_UPD: begin
					result_q.chosen_node    <= best_node_q;
					result_q.new_length     <= upd_len;
					result_q.route_distance <= '0;
					result_q.start_service  <= upd_start;
					result_q.became_empty   <= upd_empty;
					result_q.fault          <= upd_fault;
					if (job_q.is_completion) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dist_go_q <= 1'b1;
						state_q   <= ST_DIST;
					end
				end
				ST_DIST: begin
					if (dist_done) begin
						result_q.route_distance <= dist_val;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/shortest_queue_of_d_dispatcher.sv =====
// shortest_queue_of_d_dispatcher: top level with configuration registers
// depends on sqd_pkg, sqd_front, sqd_back
`default_nettype none

// Each accepted command gives exactly one result, shown on result for one cycle
// with done high; the receiver cannot stall, so results must be taken as they come.
// A command is taken when start is high and busy is low; a two-entry queue holds
// commands while the back end works. The back end scans the length memory, one read
// per candidate, and updates the chosen length, which ends a completion. An arrival
// gets its distance directly for the cycle rule, a source-chosen match or a zero
// divisor, else from the six-step serial divider. Results leave in command order.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12, 16; the
// user must write it only while the block is idle; the block does not enforce it.
module shortest_queue_of_d_dispatcher
	import sqd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire in_item_t          cmd,
	output logic                   busy,
	output logic                   done,
	output out_item_t              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t       cfg_q;
	logic       wr_stb;
	logic [2:0] reg_idx;
	logic       q_avail;
	logic       q_pop;
	job_t       q_head;

	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_nodes     <= SIZE_W'(64);
			cfg_q.topology_mode <= MODE_CYCLE;
			cfg_q.grid_width    <= SIZE_W'(8);
			cfg_q.cluster_size  <= SIZE_W'(64);
			cfg_q.hop_weight    <= WEIGHT_W'(1);
		end else if (wr_stb) begin
			case (reg_idx)
				REG_NUM_NODES:    cfg_q.num_nodes     <= pwdata[SIZE_W-1:0];
				REG_TOPOLOGY:     cfg_q.topology_mode <= pwdata[MODE_W-1:0];
				REG_GRID_WIDTH:   cfg_q.grid_width    <= pwdata[SIZE_W-1:0];
				REG_CLUSTER_SIZE: cfg_q.cluster_size  <= pwdata[SIZE_W-1:0];
				REG_HOP_WEIGHT:   cfg_q.hop_weight    <= pwdata[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_NUM_NODES:    prdata = APB_DW'(cfg_q.num_nodes);
			REG_TOPOLOGY:     prdata = APB_DW'(cfg_q.topology_mode);
			REG_GRID_WIDTH:   prdata = APB_DW'(cfg_q.grid_width);
			REG_CLUSTER_SIZE: prdata = APB_DW'(cfg_q.cluster_size);
			REG_HOP_WEIGHT:   prdata = APB_DW'(cfg_q.hop_weight);
			default:          prdata = '0;
		endcase
	end

	sqd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.avail  (q_avail),
		.pop    (q_pop),
		.head   (q_head)
	);

	sqd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.avail  (q_avail),
		.pop    (q_pop),
		.head   (q_head),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of the shortest-queue dispatcher, with its own predictor
// of per-node queue lengths and routing distances, fed through command and apb ports
// depends on sqd_pkg and shortest_queue_of_d_dispatcher
module tb_top;
	import sqd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned DRAIN_CYCLES = 50;
	localparam logic ACT_ARRIVAL    = 1'b0;
	localparam logic ACT_COMPLETION = 1'b1;

	typedef enum logic [1:0] {ENTRY_CMD, ENTRY_REG_WRITE, ENTRY_SETTLE} entry_kind_t;

	typedef struct packed {
		entry_kind_t       kind;
		in_item_t          cmd;
		logic [2:0]        reg_idx;
		logic [APB_DW-1:0] value;
		logic [6:0]        gap_pct;
	} script_entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	in_item_t          cmd = '0;
	logic              busy;
	logic              done;
	out_item_t         result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// stimulus script and bookkeeping
	script_entry_t     cmd_script[$];
	out_item_t         awaited_decisions[$];
	int unsigned       item_total = 0;
	int unsigned       issued_count = 0;
	int unsigned       taken_count = 0;
	int unsigned       result_count = 0;
	int unsigned       err_count = 0;
	int unsigned       cycle_count = 0;
	int unsigned       gap_pct_now = 0;
	logic              reg_setup = 1'b0;
	logic              reg_access = 1'b0;

	// predictor state
	logic [LEN_W-1:0]  queue_depth[NODES];
	cfg_t              model_cfg;

	shortest_queue_of_d_dispatcher u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	function automatic int unsigned span(int unsigned a, int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// distance from source to chosen node under the configured topology
	function automatic logic [DIST_W-1:0] hop_distance(logic [NODE_W-1:0] u,
			logic [NODE_W-1:0] v);
		int unsigned a, b, d, n, w, cu, cv, wt;
		a = 32'(u);
		b = 32'(v);
		d = 0;
		if (a != b) begin
			case (model_cfg.topology_mode)
				MODE_CYCLE: begin
					n = 32'(model_cfg.num_nodes);
					d = span(a, b);
					// wrap only when the ring is larger than the direct distance
					if (n > d && n - d < d)
						d = n - d;
				end
				MODE_GRID: begin
					w = 32'(model_cfg.grid_width);
					if (w != 0)
						d = span(a / w, b / w) + span(a % w, b % w);
				end
				MODE_CLUSTER: begin
					w = 32'(model_cfg.cluster_size);
					cu = (w != 0) ? a / w : 0;
					cv = (w != 0) ? b / w : 0;
					wt = (model_cfg.hop_weight != 0) ? 32'(model_cfg.hop_weight) : 1;
					d = ((cu == cv) ? 1 : 2) * wt;
				end
				default: d = 0;
			endcase
		end
		return d[DIST_W-1:0];
	endfunction

	// dispatch decision for one command, updating the queue lengths
	function automatic out_item_t decide_dispatch(in_item_t c);
		out_item_t         r;
		logic [NODE_W-1:0] cand[4];
		logic [NODE_W-1:0] pick;
		int unsigned       n, i;
		r = '0;
		if (c.action == ACT_ARRIVAL) begin
			cand = '{c.cand_a, c.cand_b, c.cand_c, c.cand_d};
			n = 32'((c.extra_count > MAX_EXTRA) ? MAX_EXTRA : c.extra_count);
			pick = c.source_node;
			// strict less-than keeps the earlier candidate on a tie
			for (i = 0; i < n; i++)
				if (queue_depth[cand[i]] < queue_depth[pick])
					pick = cand[i];
			if (queue_depth[pick] >= MAX_LENGTH) begin
				r.fault = FAULT_SAT;
			end else begin
				queue_depth[pick] = queue_depth[pick] + LEN_W'(1);
				r.start_service = (queue_depth[pick] == LEN_W'(1));
			end
			r.route_distance = hop_distance(c.source_node, pick);
		end else begin
			pick = c.completed_node;
			if (queue_depth[pick] == '0) begin
				r.fault = FAULT_EMPTY;
			end else begin
				queue_depth[pick] = queue_depth[pick] - LEN_W'(1);
				r.became_empty = (queue_depth[pick] == '0);
			end
		end
		r.chosen_node = pick;
		r.new_length = queue_depth[pick];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t mismatch %s: expected %0d got %0d", $time, name, want_v, got_v);
			err_count++;
		end
	endtask

	// script builders
	task automatic queue_cmd(input in_item_t c);
		script_entry_t e;
		e = '0;
		e.kind = ENTRY_CMD;
		e.cmd = c;
		e.gap_pct = gap_pct_now[6:0];
		cmd_script.insert(cmd_script.size(), e);
		item_total++;
	endtask

	task automatic queue_arrival(input logic [NODE_W-1:0] src, input logic [CNT_W-1:0] cnt,
			input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
			input logic [NODE_W-1:0] c, input logic [NODE_W-1:0] d);
		in_item_t t;
		t = '0;
		t.action = ACT_ARRIVAL;
		t.source_node = src;
		t.extra_count = cnt;
		t.cand_a = a;
		t.cand_b = b;
		t.cand_c = c;
		t.cand_d = d;
		queue_cmd(t);
	endtask

	task automatic queue_completion(input logic [NODE_W-1:0] node);
		in_item_t t;
		t = '0;
		t.action = ACT_COMPLETION;
		t.completed_node = node;
		queue_cmd(t);
	endtask

	task automatic queue_write(input logic [2:0] idx, input logic [APB_DW-1:0] value);
		script_entry_t e;
		e = '0;
		e.kind = ENTRY_REG_WRITE;
		e.reg_idx = idx;
		e.value = value;
		cmd_script.insert(cmd_script.size(), e);
	endtask

	function automatic logic [7:0] pick_level(int unsigned top);
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'(top / 2 + 1);
			4: return 8'(top);
			default: return 8'($urandom_range(top));
		endcase
	endfunction

	// contended nodes come from a small set so queues build up and tie
	function automatic logic [NODE_W-1:0] node_pick(logic hot);
		return hot ? NODE_W'($urandom_range(7)) : NODE_W'($urandom);
	endfunction

	// driver: one transaction or register access per step, changes at falling edge
	always @(negedge clk) begin : drive
		script_entry_t     s;
		logic              nx_start, nx_psel, nx_penable, nx_pwrite;
		in_item_t          nx_cmd;
		logic [APB_AW-1:0] nx_paddr;
		logic [APB_DW-1:0] nx_pwdata;
		nx_start = start;
		nx_cmd = cmd;
		nx_psel = psel;
		nx_penable = penable;
		nx_pwrite = pwrite;
		nx_paddr = paddr;
		nx_pwdata = pwdata;
		if (arst_n) begin
			if (reg_setup) begin
				nx_penable = 1'b1;
				reg_setup = 1'b0;
				reg_access = 1'b1;
			end else if (reg_access) begin
				nx_psel = 1'b0;
				nx_penable = 1'b0;
				nx_pwrite = 1'b0;
				reg_access = 1'b0;
			end else if (start && taken_count != issued_count) begin
				// command still waiting for busy to drop
			end else begin
				nx_start = 1'b0;
				if (cmd_script.size() != 0) begin
					s = cmd_script[0];
					case (s.kind)
						ENTRY_CMD: begin
							if ($urandom_range(99) >= 32'(s.gap_pct)) begin
								nx_start = 1'b1;
								nx_cmd = s.cmd;
								issued_count++;
								void'(cmd_script.pop_front());
							end
						end
						ENTRY_REG_WRITE: begin
							// registers change only with nothing in flight
							if (awaited_decisions.size() == 0) begin
								nx_psel = 1'b1;
								nx_pwrite = 1'b1;
								nx_paddr = {s.reg_idx, 2'b00};
								nx_pwdata = s.value;
								reg_setup = 1'b1;
								void'(cmd_script.pop_front());
							end
						end
						default: begin
							if (awaited_decisions.size() == 0)
								void'(cmd_script.pop_front());
						end
					endcase
				end
			end
		end
		start <= nx_start;
		cmd <= nx_cmd;
		psel <= nx_psel;
		penable <= nx_penable;
		pwrite <= nx_pwrite;
		paddr <= nx_paddr;
		pwdata <= nx_pwdata;
	end

	// monitor: checks results, predicts accepted commands, tracks register writes
	always @(posedge clk) begin : observe
		out_item_t   want;
		int unsigned i;
		if (!arst_n) begin
			for (i = 0; i < NODES; i++)
				queue_depth[i] = '0;
			model_cfg.num_nodes = 7'd64;
			model_cfg.topology_mode = MODE_CYCLE;
			model_cfg.grid_width = 7'd8;
			model_cfg.cluster_size = 7'd64;
			model_cfg.hop_weight = 8'd1;
		end else begin
			if (done) begin
				result_count++;
				if (awaited_decisions.size() == 0) begin
					$display("%0t unexpected result: expected none got %p", $time, result);
					err_count++;
				end else begin
					want = awaited_decisions.pop_front();
					check_field("chosen_node", 32'(want.chosen_node),
						32'(result.chosen_node));
					check_field("new_length", 32'(want.new_length),
						32'(result.new_length));
					check_field("route_distance", 32'(want.route_distance),
						32'(result.route_distance));
					check_field("start_service", 32'(want.start_service),
						32'(result.start_service));
					check_field("became_empty", 32'(want.became_empty),
						32'(result.became_empty));
					check_field("fault", 32'(want.fault), 32'(result.fault));
				end
			end
			if (start && !busy) begin
				awaited_decisions.insert(awaited_decisions.size(), decide_dispatch(cmd));
				taken_count++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_NUM_NODES:    model_cfg.num_nodes = pwdata[SIZE_W-1:0];
					REG_TOPOLOGY:     model_cfg.topology_mode = pwdata[MODE_W-1:0];
					REG_GRID_WIDTH:   model_cfg.grid_width = pwdata[SIZE_W-1:0];
					REG_CLUSTER_SIZE: model_cfg.cluster_size = pwdata[SIZE_W-1:0];
					REG_HOP_WEIGHT:   model_cfg.hop_weight = pwdata[WEIGHT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin : stimulus
		in_item_t            c;
		script_entry_t       settle;
		logic [63:0]         rnd;
		int unsigned         seg, k, settle_at;
		logic [NODE_W-1:0]   burst_node;
		logic [SIZE_W-1:0]   nn, gw, cs;
		logic [WEIGHT_W-1:0] hw;
		logic                hot;

		settle = '0;
		settle.kind = ENTRY_SETTLE;

		// directed: empty completion, ties, clamped counts, wraparound, all-ones fields
		gap_pct_now = 7;
		queue_completion(6'd5);
		queue_arrival(6'd0, 3'd0, 6'd0, 6'd0, 6'd0, 6'd0);
		queue_arrival(6'd0, 3'd1, 6'd63, 6'd0, 6'd0, 6'd0);
		queue_arrival(6'd0, 3'd2, 6'd63, 6'd0, 6'd0, 6'd0);
		queue_arrival(6'd63, 3'd4, 6'd0, 6'd63, 6'd1, 6'd2);
		queue_arrival(6'd1, 3'd7, 6'd0, 6'd63, 6'd1, 6'd20);
		queue_arrival(6'd20, 3'd5, 6'd20, 6'd20, 6'd20, 6'd2);
		queue_arrival(6'd2, 3'd6, 6'd63, 6'd0, 6'd1, 6'd32);
		queue_arrival(6'd0, 3'd3, 6'd0, 6'd0, 6'd0, 6'd5);
		queue_completion(6'd63);
		queue_completion(6'd63);
		queue_completion(6'd0);
		queue_cmd('1);
		c = '1;
		c.action = ACT_ARRIVAL;
		queue_cmd(c);
		queue_cmd('0);
		queue_completion(6'd32);
		queue_completion(6'd20);
		queue_completion(6'd2);
		queue_completion(6'd1);

		// random segments, each under its own register setting
		for (seg = 0; seg < 12; seg++) begin
			gap_pct_now = (seg < 4) ? 7 : (seg < 8) ? 80 : 0;
			nn = SIZE_W'(pick_level(127));
			gw = SIZE_W'(pick_level(127));
			cs = SIZE_W'(pick_level(127));
			hw = pick_level(255);
			// make sure the odd corners of each distance rule show up
			case (seg)
				0: nn = 7'd2;
				1: gw = 7'd0;
				2: begin
					cs = 7'd0;
					hw = 8'd0;
				end
				6: begin
					cs = 7'd1;
					hw = 8'd255;
				end
				default: ;
			endcase
			queue_write(REG_NUM_NODES, APB_DW'(nn));
			queue_write(REG_TOPOLOGY, seg % 4);
			queue_write(REG_GRID_WIDTH, APB_DW'(gw));
			queue_write(REG_CLUSTER_SIZE, APB_DW'(cs));
			queue_write(REG_HOP_WEIGHT, APB_DW'(hw));
			settle_at = $urandom_range(84);
			for (k = 0; k < 85; k++) begin
				if (k == settle_at)
					cmd_script.insert(cmd_script.size(), settle);
				hot = ($urandom_range(3) != 0);
				rnd = {$urandom, $urandom};
				c = rnd[$bits(in_item_t)-1:0];
				c.action = ($urandom_range(99) < 40) ? ACT_COMPLETION : ACT_ARRIVAL;
				c.source_node = node_pick(hot);
				c.cand_a = node_pick(hot);
				c.cand_b = node_pick(hot);
				c.cand_c = node_pick(hot);
				c.cand_d = node_pick(hot);
				c.completed_node = node_pick(hot);
				if ($urandom_range(4) != 0)
					c.extra_count = CNT_W'($urandom_range(4));
				queue_cmd(c);
			end
			// drive one node into saturation and back off it
			if (seg == 9) begin
				burst_node = NODE_W'($urandom);
				for (k = 0; k < 270; k++) begin
					rnd = {$urandom, $urandom};
					c = rnd[$bits(in_item_t)-1:0];
					c.action = ACT_ARRIVAL;
					c.source_node = burst_node;
					c.extra_count = '0;
					queue_cmd(c);
				end
				queue_arrival(burst_node, 3'd4, burst_node, burst_node, burst_node, burst_node);
				for (k = 0; k < 3; k++)
					queue_completion(burst_node);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (result_count < item_total)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_decisions.size() != 0) begin
			$display("%0t missing results: %0d never reported", $time,
				awaited_decisions.size());
			err_count++;
		end
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
